/* rtl/lgge_pkg.sv */
`default_nettype none
package lgge_pkg;

    // grid size defaults
    localparam int GRID_ROWS_DEF = 32;
    localparam int GRID_COLS_DEF = 32;

    // request fields
    localparam int REQ_W  = 2;
    localparam int ADDR_W = 5;
    localparam int CNT_W  = 4;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TOGGLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STEP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    typedef logic [CNT_W-1:0] t_nbr_cnt;

    // b3/s23 rule: live cell survives on 2 or 3, dead cell born on 3
    function automatic logic f_next_cell(input logic alive, input t_nbr_cnt cnt);
        logic res;
        if (alive) begin
            res = (cnt == t_nbr_cnt'(2)) || (cnt == t_nbr_cnt'(3));
        end else begin
            res = (cnt == t_nbr_cnt'(3));
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/lgge_row_unit.sv */
`default_nettype none
module lgge_row_unit
    import lgge_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF
) (
    input  wire logic [GRID_COLS-1:0] i_above,
    input  wire logic [GRID_COLS-1:0] i_self,
    input  wire logic [GRID_COLS-1:0] i_below,
    output logic      [GRID_COLS-1:0] o_next
);

    // rows padded with a dead cell at each edge, no wrap
    logic [GRID_COLS+1:0] w_a;
    logic [GRID_COLS+1:0] w_s;
    logic [GRID_COLS+1:0] w_b;

    assign w_a = {1'b0, i_above, 1'b0};
    assign w_s = {1'b0, i_self,  1'b0};
    assign w_b = {1'b0, i_below, 1'b0};

    // neighbour count and rule, one column each
    always_comb begin
        t_nbr_cnt cnt;
        for (int c = 0; c < GRID_COLS; c++) begin
            cnt = t_nbr_cnt'(w_a[c]) + t_nbr_cnt'(w_a[c+1]) + t_nbr_cnt'(w_a[c+2])
                + t_nbr_cnt'(w_s[c]) + t_nbr_cnt'(w_s[c+2])
                + t_nbr_cnt'(w_b[c]) + t_nbr_cnt'(w_b[c+1]) + t_nbr_cnt'(w_b[c+2]);
            o_next[c] = f_next_cell(i_self[c], cnt);
        end
    end

endmodule
`default_nettype wire

/* rtl/life_grid_generation_engine_unit.sv */
`default_nettype none
// toggle and read requests: the request passes through the read, execute and done states,
// the result beat is registered on leaving done, and the next request is taken back in idle
// step request: one grid row per cycle through a single row evaluator, then the
// addressed cell is read back through the same states as a read request
// reset: synchronous active-low, clears all row valid bits so the grid reads dead
module life_grid_generation_engine_unit
    import lgge_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_stall,
    input  wire logic [REQ_W-1:0]  i_req_type,
    input  wire logic [ADDR_W-1:0] i_row,
    input  wire logic [ADDR_W-1:0] i_col,
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_stall,
    output logic                   o_cell_alive
);

    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam int AW = (ADDR_W > RW ? ADDR_W : RW) + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PRIME0 = 3'd1;
    localparam logic [2:0] ST_PRIME1 = 3'd2;
    localparam logic [2:0] ST_RUN    = 3'd3;
    localparam logic [2:0] ST_RD     = 3'd4;
    localparam logic [2:0] ST_EXEC   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [RW-1:0]        r_cnt;
    logic [RW-1:0]        n_cnt;
    logic [REQ_W-1:0]     r_type;
    logic [RW-1:0]        r_row_a;
    logic [CW-1:0]        r_col_a;
    logic                 r_inside;
    logic                 r_res;
    logic                 n_res;
    logic                 r_rsp_valid;
    logic                 r_cell_alive;

    logic [GRID_COLS-1:0] r_mem [GRID_ROWS];
    logic [GRID_ROWS-1:0] r_row_vld;
    logic [GRID_COLS-1:0] r_rd_data;
    logic                 r_rd_ok;
    logic [GRID_COLS-1:0] r_prev;
    logic [GRID_COLS-1:0] r_cur;

    logic                 w_req_acc;
    logic                 w_inside;
    logic                 w_mem_re;
    logic [RW-1:0]        w_rd_addr;
    logic                 w_mem_we;
    logic [RW-1:0]        w_wr_addr;
    logic [GRID_COLS-1:0] w_wr_data;
    logic [GRID_COLS-1:0] w_rd_row;
    logic [GRID_COLS-1:0] w_next_row;
    logic [RW:0]          w_ahead;
    logic                 w_last;
    logic                 w_out_free;

    assign w_req_acc  = i_req_valid && !o_req_stall;
    assign o_req_stall = (r_state != ST_IDLE);
    assign w_inside   = (AW'(i_row) < AW'(GRID_ROWS)) && (AW'(i_col) < AW'(GRID_COLS));
    assign w_rd_row   = r_rd_ok ? r_rd_data : '0;
    assign w_ahead    = (RW+1)'(r_cnt) + (RW+1)'(2);
    assign w_last     = (r_cnt == RW'(GRID_ROWS - 1));
    assign w_out_free = !r_rsp_valid || !i_rsp_stall;

    // shared row evaluator
    lgge_row_unit #(
        .GRID_COLS (GRID_COLS)
    ) u_row (
        .i_above (r_prev),
        .i_self  (r_cur),
        .i_below (w_rd_row),
        .o_next  (w_next_row)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_res     = r_res;
        w_mem_re  = 1'b0;
        w_rd_addr = '0;
        w_mem_we  = 1'b0;
        w_wr_addr = r_cnt;
        w_wr_data = w_next_row;
        unique case (r_state)
            ST_IDLE: begin
                if (w_req_acc) begin
                    n_state = (i_req_type == REQ_STEP) ? ST_PRIME0 : ST_RD;
                end
            end
            ST_PRIME0: begin
                w_mem_re  = 1'b1;
                w_rd_addr = '0;
                n_state   = ST_PRIME1;
            end
            ST_PRIME1: begin
                w_mem_re  = 1'b1;
                w_rd_addr = RW'(1);
                n_cnt     = '0;
                n_state   = ST_RUN;
            end
            ST_RUN: begin
                w_mem_we  = 1'b1;
                w_mem_re  = (w_ahead < (RW+1)'(GRID_ROWS));
                w_rd_addr = w_ahead[RW-1:0];
                if (w_last) begin
                    n_state = ST_RD;
                end else begin
                    n_cnt = r_cnt + RW'(1);
                end
            end
            ST_RD: begin
                w_mem_re  = r_inside;
                w_rd_addr = r_row_a;
                n_state   = ST_EXEC;
            end
            ST_EXEC: begin
                w_wr_addr = r_row_a;
                w_wr_data = w_rd_row ^ (GRID_COLS'(1) << r_col_a);
                w_mem_we  = r_inside && (r_type == REQ_TOGGLE);
                n_res     = r_inside && (w_rd_row[r_col_a] ^ (r_type == REQ_TOGGLE));
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_rsp_valid <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_row_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rd_ok <= w_mem_re && r_row_vld[w_rd_addr];
            if (w_mem_we) begin
                r_row_vld[w_wr_addr] <= 1'b1;
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // request capture, line buffer and result
    always_ff @(posedge i_clk) begin
        if (w_req_acc) begin
            r_type   <= i_req_type;
            r_row_a  <= RW'(i_row);
            r_col_a  <= CW'(i_col);
            r_inside <= w_inside;
        end
        if (r_state == ST_PRIME1) begin
            r_prev <= '0;
            r_cur  <= w_rd_row;
        end else if (r_state == ST_RUN) begin
            r_prev <= r_cur;
            r_cur  <= w_rd_row;
        end
        r_res <= n_res;
        if (r_state == ST_DONE && w_out_free) begin
            r_cell_alive <= r_res;
        end
    end

    // grid memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_rsp_valid  = r_rsp_valid;
    assign o_cell_alive = r_cell_alive;

    // sweep never reads the row it writes
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && w_mem_re) |-> (w_rd_addr != w_wr_addr))
        else $error("sweep reads the row being written");

    // sweep counter stays inside the grid
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_cnt < RW'(GRID_ROWS - 1) || w_last))
        else $error("sweep row counter out of range");

    // a held result beat is not overwritten
    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_rsp_valid && i_rsp_stall) |=> (r_state == ST_DONE))
        else $error("result dropped while output stalled");

    // an accepted request blocks the next one
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_acc |=> o_req_stall)
        else $error("request taken while busy");

    // only toggles and the sweep write the grid
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == ST_RUN || (r_state == ST_EXEC && r_type == REQ_TOGGLE)))
        else $error("unexpected grid write");

endmodule
`default_nettype wire
